>>> rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define CHK_NEVER(lbl, clk, rst_n, expr, msg) \
  `CHK_ASSERT(lbl, clk, rst_n, !(expr), msg)

`endif

>>> rtl/modexp_pkg.sv
`default_nettype none
package modexp_pkg;
  localparam int VW   = 16;
  localparam int NC   = VW + 2;
  localparam int IDXW = $clog2(VW);
  localparam int CNTW = $clog2(VW + 1);

  localparam logic [2:0] ADDR_MODULUS  = 3'd0;
  localparam logic [2:0] ADDR_EXPONENT = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_OUT  = 3'b100
  } state_e;

  typedef enum logic [2:0] {
    OP_RED = 3'b001,
    OP_SQR = 3'b010,
    OP_MUL = 3'b100
  } op_e;

  typedef struct packed {
    logic clr;
    logic step;
    logic add_b;
    logic use_t1;
    logic use_t2;
  } cell_ctl_t;
endpackage
`default_nettype wire

>>> rtl/modular_exponentiation.sv
// a message is reduced, then squared for every exponent bit and multiplied for every set bit;
//   a zero exponent gives its result in the cycle after the transfer
// each modular multiply runs on the row of bit cells, one accumulator bit each
// one message at a time: the next message transfer follows the result transfer
// reset: asynchronous, active low; modulus resets to 1, exponent to 0, block idle
`default_nettype none
module modular_exponentiation (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       psel,
  input  wire                       penable,
  input  wire                       pwrite,
  input  wire  [2:0]                paddr,
  input  wire  [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  wire                       message_valid_i,
  output logic                      message_ready_o,
  input  wire  [modexp_pkg::VW-1:0] message_i,
  output logic                      result_valid_o,
  input  wire                       result_ready_i,
  output logic [modexp_pkg::VW-1:0] result_o
);
  import modexp_pkg::*;

  logic [VW-1:0]   modulus_q, exponent_q;
  state_e          state_q, state_d;
  op_e             op_q, op_d;
  logic [VW-1:0]   a_q, a_d, acc_q, acc_d, base_q, base_d, res_q, res_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [IDXW-1:0] idx_q, idx_d;
  logic [VW:0]     m_ext;
  logic [VW-1:0]   b_op, prod, one_mod;
  logic [NC-1:0]   r_row;
  logic [NC:0]     c0, c1, c2;
  cell_ctl_t       ctl;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q  <= VW'(1);
      exponent_q <= '0;
    end else if (wr_en) begin
      if (paddr == ADDR_MODULUS) begin
        modulus_q <= pwdata[VW-1:0];
      end else if (paddr == ADDR_EXPONENT) begin
        exponent_q <= pwdata[VW-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_MODULUS) begin
      prdata = 32'(modulus_q);
    end else if (paddr == ADDR_EXPONENT) begin
      prdata = 32'(exponent_q);
    end
  end

  // zero modulus stands for 2^VW
  assign m_ext   = {modulus_q == '0, modulus_q};
  assign one_mod = (m_ext == (VW + 1)'(1)) ? '0 : VW'(1);
  assign prod    = r_row[VW-1:0];

  always_comb begin
    case (op_q)
      OP_RED:  b_op = VW'(1);
      OP_SQR:  b_op = acc_q;
      OP_MUL:  b_op = base_q;
      default: b_op = acc_q;
    endcase
  end

  assign c0[0] = 1'b0;
  assign c1[0] = 1'b1;
  assign c2[0] = 1'b1;

  for (genvar i = 0; i < NC; i++) begin : g_cell
    logic r_lo, b_bit, m_bit, m2_bit;
    if (i == 0) begin : g_lo0
      assign r_lo   = 1'b0;
      assign m2_bit = 1'b0;
    end else begin : g_lo
      assign r_lo   = r_row[i-1];
      assign m2_bit = (i - 1 <= VW) ? m_ext[(i-1) % (VW+1)] : 1'b0;
    end
    assign b_bit = (i < VW) ? b_op[i % VW] : 1'b0;
    assign m_bit = (i <= VW) ? m_ext[i % (VW+1)] : 1'b0;
    modexp_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .r_lo_i (r_lo),
      .b_i    (b_bit),
      .m_i    (m_bit),
      .m2_i   (m2_bit),
      .c0_i   (c0[i]),
      .c1_i   (c1[i]),
      .c2_i   (c2[i]),
      .c0_o   (c0[i+1]),
      .c1_o   (c1[i+1]),
      .c2_o   (c2[i+1]),
      .r_o    (r_row[i])
    );
  end

  always_comb begin
    ctl.clr    = 1'b1;
    ctl.step   = 1'b0;
    ctl.add_b  = a_q[VW-1];
    ctl.use_t2 = c2[NC];
    ctl.use_t1 = c1[NC];
    state_d    = state_q;
    op_d       = op_q;
    a_d        = a_q;
    acc_d      = acc_q;
    base_d     = base_q;
    res_d      = res_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    case (state_q)
      S_IDLE: begin
        if (message_valid_i) begin
          if (exponent_q == '0) begin
            res_d   = VW'(1);
            state_d = S_OUT;
          end else begin
            a_d     = message_i;
            op_d    = OP_RED;
            cnt_d   = '0;
            idx_d   = IDXW'(VW - 1);
            state_d = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (cnt_q != CNTW'(VW)) begin
          ctl.clr  = 1'b0;
          ctl.step = 1'b1;
          a_d      = a_q << 1;
          cnt_d    = cnt_q + CNTW'(1);
        end else begin
          // multiply finished: pick the next one
          cnt_d = '0;
          case (op_q)
            OP_RED: begin
              base_d = prod;
              acc_d  = one_mod;
              a_d    = one_mod;
              op_d   = OP_SQR;
            end
            OP_SQR: begin
              acc_d = prod;
              a_d   = prod;
              if (exponent_q[idx_q]) begin
                op_d = OP_MUL;
              end else if (idx_q == '0) begin
                res_d   = prod;
                state_d = S_OUT;
              end else begin
                idx_d = idx_q - IDXW'(1);
              end
            end
            default: begin
              acc_d = prod;
              a_d   = prod;
              op_d  = OP_SQR;
              if (idx_q == '0) begin
                res_d   = prod;
                state_d = S_OUT;
              end else begin
                idx_d = idx_q - IDXW'(1);
              end
            end
          endcase
        end
      end
      S_OUT: begin
        if (result_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_RED;
      cnt_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    acc_q  <= acc_d;
    base_q <= base_d;
    res_q  <= res_d;
  end

  assign message_ready_o = (state_q == S_IDLE);
  assign result_valid_o  = (state_q == S_OUT);
  assign result_o        = res_q;
endmodule
`default_nettype wire

>>> rtl/modexp_cell.sv
`default_nettype none
module modexp_cell (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  modexp_pkg::cell_ctl_t ctl_i,
  input  wire                   r_lo_i,
  input  wire                   b_i,
  input  wire                   m_i,
  input  wire                   m2_i,
  input  wire                   c0_i,
  input  wire                   c1_i,
  input  wire                   c2_i,
  output logic                  c0_o,
  output logic                  c1_o,
  output logic                  c2_o,
  output logic                  r_o
);
  import modexp_pkg::*;

  logic r_q, r_d;
  logic bb, t, t1, t2;

  // t = 2r + b, t1 = t - m, t2 = t - 2m, one bit slice each
  always_comb begin
    bb   = ctl_i.add_b & b_i;
    t    = r_lo_i ^ bb ^ c0_i;
    c0_o = (r_lo_i & bb) | (r_lo_i & c0_i) | (bb & c0_i);
    t1   = t ^ ~m_i ^ c1_i;
    c1_o = (t & ~m_i) | (t & c1_i) | (~m_i & c1_i);
    t2   = t ^ ~m2_i ^ c2_i;
    c2_o = (t & ~m2_i) | (t & c2_i) | (~m2_i & c2_i);
    r_d  = r_q;
    if (ctl_i.clr) begin
      r_d = 1'b0;
    end else if (ctl_i.step) begin
      if (ctl_i.use_t2) begin
        r_d = t2;
      end else if (ctl_i.use_t1) begin
        r_d = t1;
      end else begin
        r_d = t;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q <= 1'b0;
    end else begin
      r_q <= r_d;
    end
  end

  assign r_o = r_q;
endmodule
`default_nettype wire

>>> rtl/modexp_checker.sv
`default_nettype none
`include "assert_macros.svh"
module modexp_checker (
  input wire                       clk_i,
  input wire                       rst_ni,
  input wire                       message_valid_i,
  input wire                       message_ready_o,
  input wire                       result_valid_o,
  input wire                       result_ready_i,
  input wire [modexp_pkg::VW-1:0]  result_o
);
  import modexp_pkg::*;

  `CHK_ASSERT(a_res_hold, clk_i, rst_ni, result_valid_o && !result_ready_i |=> result_valid_o, "result dropped before transfer")
  `CHK_ASSERT(a_res_stable, clk_i, rst_ni, result_valid_o && !result_ready_i |=> $stable(result_o), "result changed while stalled")
  `CHK_ASSERT(a_one_item, clk_i, rst_ni, message_valid_i && message_ready_o |=> !message_ready_o, "second message taken while busy")
  `CHK_NEVER(a_excl, clk_i, rst_ni, message_ready_o && result_valid_o, "ready while result pending")
endmodule

bind modular_exponentiation modexp_checker u_modexp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .message_valid_i (message_valid_i),
  .message_ready_o (message_ready_o),
  .result_valid_o  (result_valid_o),
  .result_ready_i  (result_ready_i),
  .result_o        (result_o)
);
`default_nettype wire
